// ===== rtl/bcu_pkg.sv =====
`default_nettype none

package bcu_pkg;

   // Field and datapath widths
   localparam int IdxW  = 7;    // n and k
   localparam int CoefW = 63;   // saturating result
   localparam int ProdW = 70;   // running value times the next factor
   localparam int CntW  = 7;    // bit counter, counts up to ProdW - 1
   localparam int RemW  = 7;    // remainder of the division by i

   localparam int MaxNDefault = 127;

   localparam logic [CntW-1:0] MulLast = CntW'(IdxW - 1);
   localparam logic [CntW-1:0] DivLast = CntW'(ProdW - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_MUL,
      ST_DIV,
      ST_CHECK,
      ST_DONE
   } seq_state_type;

   typedef enum logic [2:0] {
      OP_HOLD,
      OP_INIT_ZERO,
      OP_INIT_ONE,
      OP_MUL_STEP,
      OP_DIV_STEP,
      OP_COMMIT,
      OP_SATURATE
   } dp_op_type;

   typedef struct packed {
      dp_op_type        op;
      logic             mul_bit;
      logic [IdxW-1:0]  divisor;
   } dp_ctrl_type;

endpackage

`default_nettype wire

// ===== rtl/bcu_datapath.sv =====
`default_nettype none

// Shared shift/add-subtract unit: one ProdW-bit adder serves the serial
// multiply (add) and the restoring division (subtract and compare).
module bcu_datapath (
   input  wire logic                       clock,
   input  wire bcu_pkg::dp_ctrl_type       ctrl,
   output logic [bcu_pkg::CoefW-1:0]       acc,
   output logic                            too_big
);
   import bcu_pkg::*;

   logic [CoefW-1:0] acc_ff, acc_in;
   logic [ProdW-1:0] prod_ff, prod_in;
   logic [RemW-1:0]  rem_ff, rem_in;

   logic [ProdW-1:0] op_a, op_b;
   logic             sub;
   logic [ProdW:0]   sum;
   logic [RemW:0]    rem_sh;
   logic             q_bit;

   assign rem_sh = {rem_ff, prod_ff[ProdW-1]};

   // operand select for the shared adder
   always_comb begin
      op_a = {prod_ff[ProdW-2:0], 1'b0};
      op_b = '0;
      sub  = 1'b0;
      case (ctrl.op)
         OP_MUL_STEP: begin
            op_a = {prod_ff[ProdW-2:0], 1'b0};
            op_b = ctrl.mul_bit ? ProdW'(acc_ff) : '0;
            sub  = 1'b0;
         end
         OP_DIV_STEP: begin
            op_a = ProdW'(rem_sh);
            op_b = ProdW'(ctrl.divisor);
            sub  = 1'b1;
         end
         default: begin
            op_a = {prod_ff[ProdW-2:0], 1'b0};
            op_b = '0;
            sub  = 1'b0;
         end
      endcase
   end

   assign sum   = {1'b0, op_a} + {1'b0, (sub ? ~op_b : op_b)} + (ProdW+1)'(sub);
   assign q_bit = sum[ProdW];   // no borrow: shifted remainder >= divisor

   always_comb begin
      acc_in  = acc_ff;
      prod_in = prod_ff;
      rem_in  = rem_ff;
      case (ctrl.op)
         OP_HOLD: begin
         end
         OP_INIT_ZERO: begin
            acc_in  = '0;
            prod_in = '0;
            rem_in  = '0;
         end
         OP_INIT_ONE: begin
            acc_in  = CoefW'(1);
            prod_in = '0;
            rem_in  = '0;
         end
         OP_MUL_STEP: begin
            prod_in = sum[ProdW-1:0];
         end
         OP_DIV_STEP: begin
            prod_in = {prod_ff[ProdW-2:0], q_bit};
            rem_in  = q_bit ? sum[RemW-1:0] : rem_sh[RemW-1:0];
         end
         OP_COMMIT: begin
            acc_in  = prod_ff[CoefW-1:0];
            prod_in = '0;
            rem_in  = '0;
         end
         OP_SATURATE: begin
            acc_in  = '1;
            prod_in = '0;
            rem_in  = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
   end

   assign acc     = acc_ff;
   assign too_big = |prod_ff[ProdW-1:CoefW];

endmodule

`default_nettype wire

// ===== rtl/bcu_seq.sv =====
`default_nettype none

module bcu_seq #(
   parameter int MAX_N = bcu_pkg::MaxNDefault
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [bcu_pkg::IdxW-1:0]  n_value,
   input  wire logic [bcu_pkg::IdxW-1:0]  k_value,
   input  wire logic                      too_big,
   output bcu_pkg::dp_ctrl_type           ctrl,
   output logic                           busy,
   output logic                           done,
   output logic                           overflow
);
   import bcu_pkg::*;

   localparam logic [IdxW-1:0] MaxN = IdxW'(MAX_N);

   seq_state_type   state_ff, state_in;
   logic [IdxW-1:0] n_ff, n_in;
   logic [IdxW-1:0] k_ff, k_in;
   logic [IdxW-1:0] i_ff, i_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            ovf_ff, ovf_in;

   logic            out_of_range;
   logic [IdxW-1:0] n_minus_k;
   logic [IdxW-1:0] k_red;
   logic [IdxW-1:0] factor;
   logic [2:0]      bit_idx;

   assign out_of_range = (n_ff > MaxN) || (k_ff > n_ff);
   assign n_minus_k    = n_ff - k_ff;
   assign k_red        = (k_ff > n_minus_k) ? n_minus_k : k_ff;
   assign factor       = n_ff - k_ff + i_ff;      // k_ff already reduced here
   assign bit_idx      = 3'(IdxW - 1) - cnt_ff[2:0];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (start) state_in = ST_EVAL;
         ST_EVAL: begin
            if (out_of_range || k_red == '0) state_in = ST_DONE;
            else state_in = ST_MUL;
         end
         ST_MUL:   if (cnt_ff == MulLast) state_in = ST_DIV;
         ST_DIV:   if (cnt_ff == DivLast) state_in = ST_CHECK;
         ST_CHECK: begin
            if (too_big || i_ff == k_ff) state_in = ST_DONE;
            else state_in = ST_MUL;
         end
         ST_DONE:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // datapath control and handshake outputs
   always_comb begin
      ctrl.op      = OP_HOLD;
      ctrl.mul_bit = factor[bit_idx];
      ctrl.divisor = i_ff;
      busy         = 1'b1;
      done         = 1'b0;
      case (state_ff)
         ST_IDLE:  busy = 1'b0;
         ST_EVAL:  ctrl.op = out_of_range ? OP_INIT_ZERO : OP_INIT_ONE;
         ST_MUL:   ctrl.op = OP_MUL_STEP;
         ST_DIV:   ctrl.op = OP_DIV_STEP;
         ST_CHECK: ctrl.op = too_big ? OP_SATURATE : OP_COMMIT;
         ST_DONE:  done = 1'b1;
         default:  busy = 1'b1;
      endcase
   end

   // counters and operand registers
   always_comb begin
      n_in   = n_ff;
      k_in   = k_ff;
      i_in   = i_ff;
      cnt_in = cnt_ff;
      ovf_in = ovf_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               n_in = n_value;
               k_in = k_value;
            end
         end
         ST_EVAL: begin
            k_in   = k_red;
            i_in   = IdxW'(1);
            cnt_in = '0;
            ovf_in = 1'b0;
         end
         ST_MUL: begin
            cnt_in = (cnt_ff == MulLast) ? '0 : cnt_ff + 1'b1;
         end
         ST_DIV: begin
            cnt_in = (cnt_ff == DivLast) ? '0 : cnt_ff + 1'b1;
         end
         ST_CHECK: begin
            ovf_in = too_big;
            i_in   = i_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         ovf_ff   <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff <= n_in;
      k_ff <= k_in;
      i_ff <= i_in;
   end

   assign overflow = ovf_ff;

endmodule

`default_nettype wire

// ===== rtl/binomial_coefficient_unit.sv =====
// Binomial coefficient unit: pulse start with n and k while busy is low and
// the transaction is taken at that edge; busy then stays high until the
// result has been shown. The result appears on rsp_coefficient and
// rsp_overflow for exactly one cycle with rsp_valid high, and the receiver
// cannot stall it, so it must capture the result in that cycle. A
// transaction whose k is above n (or whose n is above MAX_N) returns 0, one
// whose reduced k' = min(k, n-k) is zero returns 1; for both the evaluate
// state leads straight to the strobe. Otherwise the running value
// C(n-k'+i, i) is built for i = 1..k' on one shared 70-bit adder: a serial
// shift-add multiply by n-k'+i, a serial restoring division by i and a
// commit make up each step. After the strobe the block returns to idle,
// where the next transaction can be taken. When a step's value passes
// 2^63-1 the loop stops early and the result is 2^63-1 with rsp_overflow
// set; since C(67,33) already passes that ceiling, no transaction runs
// more than 33 steps.
`default_nettype none

module binomial_coefficient_unit #(
   parameter int MAX_N = bcu_pkg::MaxNDefault
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire logic [bcu_pkg::IdxW-1:0]   req_n_value,
   input  wire logic [bcu_pkg::IdxW-1:0]   req_k_value,
   output logic                            rsp_valid,
   output logic [bcu_pkg::CoefW-1:0]       rsp_coefficient,
   output logic                            rsp_overflow
);
   import bcu_pkg::*;

   dp_ctrl_type      ctrl;
   logic             too_big;
   logic [CoefW-1:0] acc;

   // sequencer: holds n, k, the step index i and the bit counter
   bcu_seq #(
      .MAX_N (MAX_N)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .n_value  (req_n_value),
      .k_value  (req_k_value),
      .too_big  (too_big),
      .ctrl     (ctrl),
      .busy     (busy),
      .done     (rsp_valid),
      .overflow (rsp_overflow)
   );

   // shared arithmetic: running value, product/quotient and remainder
   bcu_datapath u_datapath (
      .clock   (clock),
      .ctrl    (ctrl),
      .acc     (acc),
      .too_big (too_big)
   );

   // the running value register holds the result during the strobe cycle
   assign rsp_coefficient = acc;

endmodule

`default_nettype wire

// ===== bench/tb_binomial_coefficient_unit.sv =====
`timescale 1ns / 100ps

// Expected coefficients, kept in order of acceptance.
class coefficient_scoreboard;
   typedef struct packed {
      logic [bcu_pkg::CoefW-1:0] coefficient;
      logic                      overflow;
   } coefficient_result_type;

   coefficient_result_type pending_coefficients[$];
   int unsigned            mismatch_count = 0;

   // C(n,k) with saturation at 2^63-1; the running value grows with i,
   // so the first step that passes the ceiling settles the overflow.
   function void binomial_predict(input logic [bcu_pkg::IdxW-1:0] n_value,
                                  input logic [bcu_pkg::IdxW-1:0] k_value,
                                  output coefficient_result_type expected);
      logic [127:0]             running;
      logic [127:0]             ceiling;
      logic [bcu_pkg::IdxW-1:0] k_reduced;
      int unsigned              step;
      expected.coefficient = '0;
      expected.overflow    = 1'b0;
      if (n_value > bcu_pkg::MaxNDefault || k_value > n_value) return;
      ceiling   = {65'd0, {63{1'b1}}};
      k_reduced = (k_value > n_value - k_value) ? n_value - k_value : k_value;
      running   = 128'd1;
      for (step = 1; step <= k_reduced; step++) begin
         running = running * (n_value - k_reduced + step) / step;
         if (running > ceiling) begin
            expected.overflow = 1'b1;
            break;
         end
      end
      expected.coefficient = expected.overflow ? ceiling[62:0] : running[62:0];
   endfunction

   function void note_pair(input logic [bcu_pkg::IdxW-1:0] n_value,
                           input logic [bcu_pkg::IdxW-1:0] k_value);
      coefficient_result_type expected;
      binomial_predict(n_value, k_value, expected);
      pending_coefficients.push_back(expected);
   endfunction

   function void check_result(input logic [bcu_pkg::CoefW-1:0] coefficient,
                              input logic overflow);
      coefficient_result_type expected;
      if (pending_coefficients.size() == 0) begin
         $display("%0t: unexpected result coefficient=%0d overflow=%0b",
                  $time, coefficient, overflow);
         mismatch_count++;
         return;
      end
      expected = pending_coefficients.pop_front();
      if (coefficient !== expected.coefficient) begin
         $display("%0t: coefficient expected %0d actual %0d",
                  $time, expected.coefficient, coefficient);
         mismatch_count++;
      end
      if (overflow !== expected.overflow) begin
         $display("%0t: overflow expected %0b actual %0b",
                  $time, expected.overflow, overflow);
         mismatch_count++;
      end
   endfunction
endclass

module tb_binomial_coefficient_unit;
   import bcu_pkg::*;

   // Slowest correct run: ~130 transactions, each as long as the longest
   // serial loop, plus sender gaps; allow several times that before giving up.
   localparam int unsigned CycleLimit    = 3_000_000;
   localparam int unsigned ItemsPerPhase = 36;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [IdxW-1:0]      req_n_value;
   logic [IdxW-1:0]      req_k_value;
   logic                 rsp_valid;
   logic [CoefW-1:0]     rsp_coefficient;
   logic                 rsp_overflow;

   int unsigned          cycle_count;
   coefficient_scoreboard ledger;

   binomial_coefficient_unit DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_n_value     (req_n_value),
      .req_k_value     (req_k_value),
      .rsp_valid       (rsp_valid),
      .rsp_coefficient (rsp_coefficient),
      .rsp_overflow    (rsp_overflow)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // Sample both channels at the rising edge, before the block updates.
   // Check a result before noting a new transaction at the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) ledger.check_result(rsp_coefficient, rsp_overflow);
         if (start && !busy) ledger.note_pair(req_n_value, req_k_value);
      end
   end

   // Bound the run; a lost result ends up here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("binomial_coefficient_unit: mismatch");
         $finish;
      end
   end

   // Offer one transaction and hold it until the block takes it. Start is
   // left high on return: the next call either replaces the payload at the
   // next falling edge or drops start for an idle gap.
   task automatic send_pair(input logic [IdxW-1:0] n_value,
                            input logic [IdxW-1:0] k_value,
                            input int unsigned idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      req_n_value <= n_value;
      req_k_value <= k_value;
      start       <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   // Small reduced k in 45% of pairs to keep the serial loop short, as many
   // full-range pairs that reach the overflow region, and a share of k above n.
   task automatic random_pair(output logic [IdxW-1:0] n_value,
                              output logic [IdxW-1:0] k_value);
      int unsigned pick;
      int unsigned k_reduced;
      pick    = $urandom_range(99);
      n_value = IdxW'($urandom_range(127));
      if (pick < 10) begin
         if (n_value == 7'd127) n_value = IdxW'($urandom_range(126));
         k_value = IdxW'($urandom_range(127, n_value + 1));
      end else if (pick < 55) begin
         k_reduced = $urandom_range(6);
         if (k_reduced > n_value) k_reduced = n_value;
         k_value = $urandom_range(1) ? IdxW'(k_reduced) : IdxW'(n_value - k_reduced);
      end else begin
         k_value = IdxW'($urandom_range(n_value, 0));
      end
   endtask

   task automatic run_random_phase(input int unsigned idle_pct);
      logic [IdxW-1:0] n_value;
      logic [IdxW-1:0] k_value;
      repeat (ItemsPerPhase) begin
         random_pair(n_value, k_value);
         send_pair(n_value, k_value, idle_pct);
      end
   endtask

   initial begin
      cycle_count = 0;
      reset       = 1'b1;
      start       = 1'b0;
      req_n_value = '0;
      req_k_value = '0;
      ledger      = new();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: field extremes, k above n, k zero and k equal to n,
      // symmetry, the largest coefficients that fit and the first that do not.
      send_pair(7'd0,   7'd0,   0);
      send_pair(7'd127, 7'd127, 0);
      send_pair(7'd127, 7'd0,   0);
      send_pair(7'd0,   7'd127, 0);
      send_pair(7'd5,   7'd6,   0);
      send_pair(7'd126, 7'd127, 0);
      send_pair(7'd1,   7'd1,   0);
      send_pair(7'd1,   7'd0,   0);
      send_pair(7'd10,  7'd3,   0);
      send_pair(7'd10,  7'd7,   0);
      send_pair(7'd127, 7'd1,   0);
      send_pair(7'd127, 7'd126, 0);
      send_pair(7'd127, 7'd2,   0);
      send_pair(7'd66,  7'd33,  0);
      send_pair(7'd67,  7'd33,  0);
      send_pair(7'd67,  7'd34,  0);
      send_pair(7'd64,  7'd32,  0);
      send_pair(7'd62,  7'd31,  0);
      send_pair(7'd127, 7'd63,  0);
      send_pair(7'd127, 7'd64,  0);
      send_pair(7'd100, 7'd10,  0);
      send_pair(7'd85,  7'd42,  0);

      // Random: back to back, sparse sender, mostly busy sender.
      run_random_phase(0);
      run_random_phase(71);
      run_random_phase(9);

      @(negedge clock);
      start <= 1'b0;

      // Drain outstanding results, then let the block settle.
      while (ledger.pending_coefficients.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (ledger.mismatch_count == 0) begin
         $display("binomial_coefficient_unit: match");
      end else begin
         $display("binomial_coefficient_unit: mismatch");
      end
      $finish;
   end
endmodule

// ===== files.f =====
rtl/bcu_pkg.sv
rtl/bcu_datapath.sv
rtl/bcu_seq.sv
rtl/binomial_coefficient_unit.sv
bench/tb_binomial_coefficient_unit.sv
